// ===== rtl/log_level_keyword_matcher_assert.svh =====
// assertion macros for the severity keyword matcher checker
`ifndef LOG_LEVEL_KEYWORD_MATCHER_ASSERT_SVH
`define LOG_LEVEL_KEYWORD_MATCHER_ASSERT_SVH

// checked only while out of reset
`define LKLM_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("lklm assertion failed");

// checked in and out of reset
`define LKLM_ASSERT_RST(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("lklm reset assertion failed");

`endif

// ===== rtl/lklm_pkg.sv =====
// types, constants and trie tables of the severity keyword matcher
package lklm_pkg;

  localparam int NODE_COUNT = 63;
  localparam int NODE_W = 6;

  typedef logic [NODE_W-1:0] node_t;

  typedef enum logic [3:0] {
    PH_WALK      = 4'b0001,
    PH_ENDED     = 4'b0010,
    PH_UNMATCHED = 4'b0100,
    PH_BAD       = 4'b1000
  } phase_t;

  localparam logic [1:0] STATUS_MATCH   = 2'd0;
  localparam logic [1:0] STATUS_UNKNOWN = 2'd1;
  localparam logic [1:0] STATUS_BAD     = 2'd2;

  localparam logic signed [31:0] LEVEL_UNKNOWN  = -32'sd1;
  localparam logic signed [31:0] LEVEL_BAD_CHAR = -32'sd2;
  localparam logic signed [31:0] LEVEL_ALL      = 32'sh8000_0000;
  localparam logic signed [31:0] LEVEL_OFF      = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] LEVEL_FINEST   = 32'sd10000;
  localparam logic signed [31:0] LEVEL_VERBOSE  = 32'sd10000;
  localparam logic signed [31:0] LEVEL_TRACE    = 32'sd20000;
  localparam logic signed [31:0] LEVEL_DEBUG    = 32'sd30000;
  localparam logic signed [31:0] LEVEL_INFO     = 32'sd40000;
  localparam logic signed [31:0] LEVEL_NOTICE   = 32'sd50000;
  localparam logic signed [31:0] LEVEL_WARN     = 32'sd60000;
  localparam logic signed [31:0] LEVEL_ERROR    = 32'sd70000;
  localparam logic signed [31:0] LEVEL_SEVERE   = 32'sd80000;
  localparam logic signed [31:0] LEVEL_CRITICAL = 32'sd90000;

  localparam logic [7:0] CHAR_NUL = 8'h00;
  localparam logic [7:0] CHAR_A   = 8'h41;
  localparam logic [7:0] CHAR_Z   = 8'h5A;

  // letter leading into each node, node 0 first
  localparam logic [8*NODE_COUNT-1:0] NODE_LETTERS =
    " ALLCRITICALDEBUGERRORFINESTINFONOTICEOFFSEVERETRACEVERBOSEWARN";

  function automatic logic [7:0] node_letter(input node_t n);
    node_t ridx;
    ridx = node_t'(NODE_COUNT - 1) - n;
    if (n > node_t'(NODE_COUNT - 1)) begin
      return CHAR_NUL;
    end
    return NODE_LETTERS[{ridx, 3'b000} +: 8];
  endfunction

  function automatic logic signed [31:0] node_level(input node_t n);
    logic signed [31:0] v;
    case (n)
      6'd3:    v = LEVEL_ALL;
      6'd11:   v = LEVEL_CRITICAL;
      6'd16:   v = LEVEL_DEBUG;
      6'd21:   v = LEVEL_ERROR;
      6'd27:   v = LEVEL_FINEST;
      6'd31:   v = LEVEL_INFO;
      6'd37:   v = LEVEL_NOTICE;
      6'd40:   v = LEVEL_OFF;
      6'd46:   v = LEVEL_SEVERE;
      6'd51:   v = LEVEL_TRACE;
      6'd58:   v = LEVEL_VERBOSE;
      6'd62:   v = LEVEL_WARN;
      default: v = LEVEL_UNKNOWN;
    endcase
    return v;
  endfunction

  function automatic logic node_is_leaf(input node_t n);
    return node_level(n) != LEVEL_UNKNOWN;
  endfunction

  // first node of the word starting with each letter, zero for none
  function automatic node_t root_child(input logic [4:0] letter);
    node_t ch;
    case (letter)
      5'd0:    ch = 6'd1;
      5'd2:    ch = 6'd4;
      5'd3:    ch = 6'd12;
      5'd4:    ch = 6'd17;
      5'd5:    ch = 6'd22;
      5'd8:    ch = 6'd28;
      5'd13:   ch = 6'd32;
      5'd14:   ch = 6'd38;
      5'd18:   ch = 6'd41;
      5'd19:   ch = 6'd47;
      5'd21:   ch = 6'd52;
      5'd22:   ch = 6'd59;
      default: ch = 6'd0;
    endcase
    return ch;
  endfunction

endpackage

// ===== rtl/log_level_keyword_matcher.sv =====
// severity keyword matcher: trie walk per character, one result per word
//
// Input channel: in_valid / in_stall carries one byte of a severity word per
// request (in_char_code) and in_is_last on the final byte. A zero byte ends
// the word; bytes after it up to the last one are ignored.
// Output channel: out_valid / out_stall carries one result per word:
// out_level_value (numeric level, -1 unknown, -2 bad character) and
// out_match_status (0 matched, 1 unknown or prefix, 2 bad character).
// Throughput: one byte per cycle when not stalled; each byte makes one trie
// transition in the node and phase registers, which feed straight back for
// the next byte; the result is registered in the output or skid register.
// Stall: the output register is backed by a one-entry skid register, so the
// input keeps taking bytes while a result waits; in_stall rises only once
// both hold a result, and falls the cycle after the output drains.
// Reset: synchronous, active low; the walk returns to the root and both
// result registers empty. No clearing pass is needed.
module log_level_keyword_matcher (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_char_code,
  input  logic               in_is_last,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_level_value,
  output logic [1:0]         out_match_status
);
  import lklm_pkg::*;

  node_t              node_r, node_nxt;
  phase_t             phase_r, phase_nxt;
  logic               accept, push, pop;
  logic [4:0]         letter;
  node_t              child;
  logic signed [31:0] res_level;
  logic [1:0]         res_status;

  logic               out_valid_r, skid_valid_r;
  logic signed [31:0] out_level_r, skid_level_r;
  logic [1:0]         out_status_r, skid_status_r;

  assign accept = in_valid && !in_stall;
  assign push   = accept && in_is_last;
  assign pop    = out_valid_r && !out_stall;
  assign letter = 5'(in_char_code - CHAR_A);
  assign child  = root_child(letter);

  // trie transition
  always_comb begin
    node_nxt  = node_r;
    phase_nxt = phase_r;
    if (phase_r == PH_WALK) begin
      if (in_char_code == CHAR_NUL) begin
        phase_nxt = PH_ENDED;
      end else if (in_char_code < CHAR_A || in_char_code > CHAR_Z) begin
        phase_nxt = PH_BAD;
      end else if (node_r == '0) begin
        if (child == '0) begin
          phase_nxt = PH_UNMATCHED;
        end else begin
          node_nxt = child;
        end
      end else if (node_is_leaf(node_r) ||
                   node_letter(node_r + node_t'(1)) != in_char_code) begin
        phase_nxt = PH_UNMATCHED;
      end else begin
        node_nxt = node_r + node_t'(1);
      end
    end
  end

  // result of the word
  always_comb begin
    if (phase_nxt == PH_BAD) begin
      res_level  = LEVEL_BAD_CHAR;
      res_status = STATUS_BAD;
    end else if (phase_nxt == PH_UNMATCHED) begin
      res_level  = LEVEL_UNKNOWN;
      res_status = STATUS_UNKNOWN;
    end else if (node_is_leaf(node_nxt)) begin
      res_level  = node_level(node_nxt);
      res_status = STATUS_MATCH;
    end else begin
      res_level  = LEVEL_UNKNOWN;
      res_status = STATUS_UNKNOWN;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_r  <= '0;
      phase_r <= PH_WALK;
    end else if (accept) begin
      if (in_is_last) begin
        node_r  <= '0;
        phase_r <= PH_WALK;
      end else begin
        node_r  <= node_nxt;
        phase_r <= phase_nxt;
      end
    end
  end

  // output register with skid entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || pop) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= push;
      end
    end else if (push) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || pop) begin
      if (skid_valid_r) begin
        out_level_r  <= skid_level_r;
        out_status_r <= skid_status_r;
      end else if (push) begin
        out_level_r  <= res_level;
        out_status_r <= res_status;
      end
    end else if (push) begin
      skid_level_r  <= res_level;
      skid_status_r <= res_status;
    end
  end

  assign in_stall         = skid_valid_r;
  assign out_valid        = out_valid_r;
  assign out_level_value  = out_level_r;
  assign out_match_status = out_status_r;

endmodule

// ===== rtl/lklm_checker.sv =====
// port checker for the severity keyword matcher, bound to the top level
`include "log_level_keyword_matcher_assert.svh"

module lklm_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [31:0] out_level_value,
  input logic [1:0]         out_match_status
);
  import lklm_pkg::*;

  logic level_ok;

  // status agrees with the level it comes with
  assign level_ok =
    (out_match_status == STATUS_MATCH && out_level_value != LEVEL_UNKNOWN &&
     out_level_value != LEVEL_BAD_CHAR) ||
    (out_match_status == STATUS_UNKNOWN && out_level_value == LEVEL_UNKNOWN) ||
    (out_match_status == STATUS_BAD && out_level_value == LEVEL_BAD_CHAR);

  `LKLM_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid)
  `LKLM_ASSERT(a_out_stable, out_valid && out_stall |=> $stable({out_level_value, out_match_status}))
  `LKLM_ASSERT(a_status_level, out_valid |-> level_ok)
  `LKLM_ASSERT(a_stall_needs_result, in_stall |-> out_valid)
  `LKLM_ASSERT_RST(a_reset_idle, !rst_n |=> !out_valid && !in_stall)

endmodule

bind log_level_keyword_matcher lklm_checker u_lklm_checker (.*);

// ===== bench/log_level_keyword_matcher_monitor.sv =====
`timescale 1ns / 1ps
// request monitor, severity predictor and result comparison for the keyword matcher bench
module log_level_keyword_matcher_monitor (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [7:0]         in_char_code,
  input  logic               in_is_last,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [31:0] out_level_value,
  input  logic [1:0]         out_match_status,
  output int                 failures,
  output int                 outstanding
);
  import lklm_pkg::*;

  typedef struct packed {
    logic signed [31:0] level;
    logic [1:0]         status;
  } severity_t;

  logic [7:0]         trie_char [64];
  logic signed [31:0] trie_level [64];
  node_t              trie_entry [26];

  node_t     walk_node;
  phase_t    walk_phase;
  severity_t expected_results [$];

  // words are laid out as consecutive node chains, in this order
  initial begin : build_trie
    string              words [12];
    logic signed [31:0] levels [12];
    string              s;
    int                 n;
    words = '{"ALL", "CRITICAL", "DEBUG", "ERROR", "FINEST", "INFO", "NOTICE", "OFF",
              "SEVERE", "TRACE", "VERBOSE", "WARN"};
    levels = '{32'sh8000_0000, 32'sd90000, 32'sd30000, 32'sd70000, 32'sd10000,
               32'sd40000, 32'sd50000, 32'sh7FFF_FFFF, 32'sd80000, 32'sd20000,
               32'sd10000, 32'sd60000};
    foreach (trie_char[i]) begin
      trie_char[i] = CHAR_NUL;
      trie_level[i] = LEVEL_UNKNOWN;
    end
    foreach (trie_entry[i]) begin
      trie_entry[i] = '0;
    end
    n = 1;
    for (int w = 0; w < 12; w++) begin
      s = words[w];
      trie_entry[s[0] - CHAR_A] = node_t'(n);
      for (int i = 0; i < s.len(); i++) begin
        trie_char[n] = s[i];
        n++;
      end
      trie_level[n - 1] = levels[w];
    end
    walk_node = '0;
    walk_phase = PH_WALK;
  end

  task automatic track_byte(input logic [7:0] c, input logic last);
    severity_t r;
    if (walk_phase == PH_WALK) begin
      if (c == CHAR_NUL) begin
        walk_phase = PH_ENDED;
      end else if (c < CHAR_A || c > CHAR_Z) begin
        walk_phase = PH_BAD;
      end else if (walk_node == '0) begin
        if (trie_entry[c - CHAR_A] == '0) begin
          walk_phase = PH_UNMATCHED;
        end else begin
          walk_node = trie_entry[c - CHAR_A];
        end
      end else if (trie_level[walk_node] != LEVEL_UNKNOWN ||
                   trie_char[walk_node + 1] != c) begin
        walk_phase = PH_UNMATCHED;
      end else begin
        walk_node = walk_node + 1'b1;
      end
    end
    if (last) begin
      case (walk_phase)
        PH_BAD: begin
          r.level = LEVEL_BAD_CHAR;
          r.status = STATUS_BAD;
        end
        PH_UNMATCHED: begin
          r.level = LEVEL_UNKNOWN;
          r.status = STATUS_UNKNOWN;
        end
        default: begin
          r.level = trie_level[walk_node];
          r.status = (r.level == LEVEL_UNKNOWN) ? STATUS_UNKNOWN : STATUS_MATCH;
        end
      endcase
      expected_results.push_back(r);
      walk_node = '0;
      walk_phase = PH_WALK;
    end
  endtask

  always @(posedge clk) begin : compare
    severity_t want;
    if (!rst_n) begin
      expected_results.delete();
      walk_node = '0;
      walk_phase = PH_WALK;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          failures++;
          $error("unexpected result: level_value %0d match_status %0d",
                 out_level_value, out_match_status);
        end else begin
          want = expected_results.pop_front();
          if (out_level_value !== want.level) begin
            failures++;
            $error("level_value expected %0d actual %0d", want.level, out_level_value);
          end
          if (out_match_status !== want.status) begin
            failures++;
            $error("match_status expected %0d actual %0d", want.status, out_match_status);
          end
        end
      end
      if (in_valid && !in_stall) begin
        track_byte(in_char_code, in_is_last);
      end
    end
    outstanding = expected_results.size();
  end

endmodule

// ===== bench/log_level_keyword_matcher_test.sv =====
`timescale 1ns / 1ps
// testbench top for the severity keyword matcher: clock, reset, stimulus and verdict
module log_level_keyword_matcher_test;
  import lklm_pkg::*;

  localparam int REQUEST_TARGET = 1350;
  localparam int QUIET_LIMIT = 1000;
  localparam int LONG_HOLD = 120;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [7:0]         in_char_code;
  logic               in_is_last;
  logic               out_valid;
  logic               out_stall;
  logic signed [31:0] out_level_value;
  logic [1:0]         out_match_status;

  int failures;
  int outstanding;

  int sender_idle_pct = 8;
  int stall_pct = 63;
  int hold_requests = 0;
  int holds_served = 0;
  int requests_sent = 0;

  logic [7:0] word_bytes [$];
  string      keywords [12];

  log_level_keyword_matcher dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_char_code     (in_char_code),
    .in_is_last       (in_is_last),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_level_value  (out_level_value),
    .out_match_status (out_match_status)
  );

  log_level_keyword_matcher_monitor result_monitor (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_char_code     (in_char_code),
    .in_is_last       (in_is_last),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_level_value  (out_level_value),
    .out_match_status (out_match_status),
    .failures         (failures),
    .outstanding      (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin : receiver
    int hold_left;
    hold_left = 0;
    out_stall <= 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left == 0 && holds_served != hold_requests) begin
        hold_left = LONG_HOLD;
        holds_served++;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("Test completed with failures");
    $finish;
  end

  task automatic put_byte(input logic [7:0] code, input logic last);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_char_code <= code;
    in_is_last <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_word();
    for (int i = 0; i < word_bytes.size(); i++) begin
      put_byte(word_bytes[i], i == word_bytes.size() - 1);
    end
    requests_sent += word_bytes.size();
  endtask

  task automatic append_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      word_bytes.push_back(s[i]);
    end
  endtask

  task automatic send_text(input string s);
    word_bytes.delete();
    append_text(s);
    send_word();
  endtask

  task automatic build_random_word();
    string w;
    int    kind;
    int    cut;
    int    idx;
    w = keywords[$urandom_range(0, 11)];
    kind = $urandom_range(0, 99);
    word_bytes.delete();
    append_text(w);
    if (kind >= 45 && kind < 55) begin
      // prefix, sometimes closed by a zero byte
      cut = $urandom_range(0, w.len() - 1);
      while (word_bytes.size() > cut) void'(word_bytes.pop_back());
      if (cut == 0 || $urandom_range(0, 1) == 1) begin
        word_bytes.push_back(CHAR_NUL);
      end
    end else if (kind >= 55 && kind < 65) begin
      repeat ($urandom_range(1, 3)) word_bytes.push_back(8'($urandom_range(CHAR_A, CHAR_Z)));
    end else if (kind >= 65 && kind < 75) begin
      word_bytes.push_back(CHAR_NUL);
      repeat ($urandom_range(0, 3)) word_bytes.push_back(8'($urandom_range(0, 255)));
    end else if (kind >= 75 && kind < 85) begin
      idx = $urandom_range(0, word_bytes.size() - 1);
      word_bytes[idx] = 8'($urandom_range(0, 255));
    end else if (kind >= 85 && kind < 90) begin
      idx = $urandom_range(0, word_bytes.size() - 1);
      word_bytes[idx] = word_bytes[idx] | 8'h20;
    end else if (kind >= 90) begin
      word_bytes.delete();
      repeat ($urandom_range(1, 6)) begin
        if ($urandom_range(0, 1) == 1) begin
          word_bytes.push_back(8'($urandom_range(CHAR_A, CHAR_Z)));
        end else begin
          word_bytes.push_back(8'($urandom_range(0, 255)));
        end
      end
    end
  endtask

  initial begin : stimulus
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_char_code <= CHAR_NUL;
    in_is_last <= 1'b0;
    keywords = '{"ALL", "CRITICAL", "DEBUG", "ERROR", "FINEST", "INFO", "NOTICE", "OFF",
                 "SEVERE", "TRACE", "VERBOSE", "WARN"};
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_text("ALL");
    send_text("OFF");
    word_bytes = '{CHAR_NUL};
    send_word();
    send_text("WAR");
    send_text("WARNS");
    send_text("In");
    word_bytes = '{8'hFF};
    send_word();
    send_text("B");
    send_text("@");
    send_text("[");
    word_bytes.delete();
    append_text("OFF");
    word_bytes.push_back(CHAR_NUL);
    word_bytes.push_back(8'h7F);
    send_word();

    while (requests_sent < REQUEST_TARGET / 3) begin
      build_random_word();
      send_word();
    end
    sender_idle_pct = 63;
    stall_pct = 8;
    while (requests_sent < 2 * REQUEST_TARGET / 3) begin
      build_random_word();
      send_word();
    end
    sender_idle_pct = 0;
    stall_pct = 0;
    hold_requests++;
    while (requests_sent < REQUEST_TARGET) begin
      build_random_word();
      send_word();
    end
    in_valid <= 1'b0;

    while (outstanding != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
